// ===== design/lahc_pkg.sv =====
// ----------------------------------------------------------------------------
// lahc_pkg
// Shared types and constants of the leg anchor height conditioner.
// ----------------------------------------------------------------------------
`default_nettype none

package lahc_pkg;

   localparam int unsigned NUM_LEGS_DEF = 4;
   localparam int unsigned IN_LEGS      = 4;
   localparam int unsigned MEAS_W       = 32;
   localparam int unsigned CSR_DATA_W   = 32;
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam int unsigned LIM_W        = 31;
   localparam int unsigned GAIN_W       = 17;
   localparam int unsigned MINL_W       = 3;
   localparam int unsigned CNT_W        = 3;
   localparam int unsigned SUM_W        = 36;
   localparam int unsigned ACC_W        = 50;
   localparam int unsigned DIV_STEPS    = SUM_W / 2;
   localparam int unsigned DIV_CNT_W    = $clog2(DIV_STEPS);
   localparam int unsigned FRAC_W       = 16;

   localparam logic [GAIN_W-1:0] ONE_Q16  = GAIN_W'(65536);
   localparam int unsigned        HALF_Q16 = 32768;

   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2147483647);
   localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;
   localparam logic signed [MEAS_W-1:0] MEAS_MAX = {1'b0, {(MEAS_W-1){1'b1}}};
   localparam logic signed [MEAS_W-1:0] MEAS_MIN = {1'b1, {(MEAS_W-1){1'b0}}};

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_CORRECTION_ENABLE = 3'd0,
      CSR_FLAT_GROUND_MODE  = 3'd1,
      CSR_GROUND_OFFSET     = 3'd2,
      CSR_VARIANCE_POSITIVE = 3'd3,
      CSR_MAX_INNOVATION    = 3'd4,
      CSR_SMOOTHING_GAIN    = 3'd5,
      CSR_MIN_STANCE_LEGS   = 3'd6
   } csr_index_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_START,
      S_LEG,
      S_SUM_A,
      S_SUM_B,
      S_AVG,
      S_DIV,
      S_DIV_FIX,
      S_FLAT,
      S_SMOOTH,
      S_MUL1,
      S_ACC1,
      S_MUL2,
      S_ACC2,
      S_CLAMP,
      S_BOUND,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic [IN_LEGS-1:0]       stance_mask;
      logic [IN_LEGS-1:0]       offset_ok_mask;
      logic signed [MEAS_W-1:0] leg0_foot_offset;
      logic signed [MEAS_W-1:0] leg1_foot_offset;
      logic signed [MEAS_W-1:0] leg2_foot_offset;
      logic signed [MEAS_W-1:0] leg3_foot_offset;
      logic signed [MEAS_W-1:0] estimated_base_height;
      logic signed [MEAS_W-1:0] reported_base_height;
      logic                     reported_height_ok;
      logic [CNT_W-1:0]         stance_leg_count;
   } req_data_type;

   typedef struct packed {
      logic                     update_valid;
      logic signed [MEAS_W-1:0] height_measurement;
      logic                     innovation_clamped;
   } rsp_data_type;

   typedef struct packed {
      logic signed [ACC_W-1:0]  sum;
      logic signed [MEAS_W-1:0] sat;
      logic signed [MEAS_W-1:0] sat_q16;
   } alu_res_type;

endpackage

`default_nettype wire

// ===== design/lahc_if.sv =====
// ----------------------------------------------------------------------------
// lahc_req_if / lahc_rsp_if
// Valid/ready channels for samples and height measurements.
// ----------------------------------------------------------------------------
`default_nettype none

interface lahc_req_if;
   import lahc_pkg::*;
   logic         valid;
   logic         ready;
   req_data_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface lahc_rsp_if;
   import lahc_pkg::*;
   logic         valid;
   logic         ready;
   rsp_data_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/lahc_alu.sv =====
// ----------------------------------------------------------------------------
// lahc_alu
// Shared add/subtract unit with 32-bit saturation of the plain and Q16 sums.
// ----------------------------------------------------------------------------
`default_nettype none

module lahc_alu (
   input  wire logic signed [lahc_pkg::ACC_W-1:0] a_in,
   input  wire logic signed [lahc_pkg::ACC_W-1:0] b_in,
   input  wire logic                              sub,
   output lahc_pkg::alu_res_type                  res
);
   import lahc_pkg::*;

   logic signed [ACC_W-1:0] sum;
   logic signed [ACC_W-1:0] sum_q16;

   function automatic logic signed [MEAS_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [MEAS_W-1:0] r;
      if (v > SAT_HI) begin
         r = MEAS_MAX;
      end else if (v < SAT_LO) begin
         r = MEAS_MIN;
      end else begin
         r = v[MEAS_W-1:0];
      end
      return r;
   endfunction

   assign sum         = sub ? (a_in - b_in) : (a_in + b_in);
   assign sum_q16     = sum >>> FRAC_W;
   assign res.sum     = sum;
   assign res.sat     = sat32(sum);
   assign res.sat_q16 = sat32(sum_q16);

endmodule

`default_nettype wire

// ===== design/leg_anchor_height_conditioner_core.sv =====
// ----------------------------------------------------------------------------
// leg_anchor_height_conditioner_core
// Forms a smoothed, bounded base-height measurement from each odometry sample.
// ----------------------------------------------------------------------------
// One sample is taken at a time and yields exactly one result transfer. The
// time that a sample is held is set by the single shared adder, which takes
// up to three passes per leg, by the divider that produces two quotient bits
// a cycle, by the smoothing that runs both products through one multiplier,
// and by any wait for a free output slot. A finished result waits in an
// output register, and the next sample is taken as soon as the sequencer is
// back at idle.
`default_nettype none

module leg_anchor_height_conditioner_core #(
   parameter int unsigned NUM_LEGS = lahc_pkg::NUM_LEGS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   lahc_req_if.sink                                 req_chan,
   lahc_rsp_if.source                               rsp_chan,
   input  wire logic                                csr_we,
   input  wire logic [lahc_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire logic [lahc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import lahc_pkg::*;

   localparam int unsigned LEG_W  = (NUM_LEGS > 1) ? $clog2(NUM_LEGS) : 1;
   localparam int unsigned LEGX_W = 4;

   state_type state_ff, state_in;

   logic                     en_ff, en_in;
   logic                     flat_ff, flat_in;
   logic signed [MEAS_W-1:0] gnd_ff, gnd_in;
   logic                     var_ff, var_in;
   logic [LIM_W-1:0]         lim_ff, lim_in;
   logic [GAIN_W-1:0]        gain_ff, gain_in;
   logic [MINL_W-1:0]        minl_ff, minl_in;

   req_data_type             in_ff, in_in;
   logic [LEG_W-1:0]         leg_ff, leg_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [1:0]               rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]     dcnt_ff, dcnt_in;
   logic                     neg_ff, neg_in;
   logic                     dir_ff, dir_in;
   logic signed [MEAS_W-1:0] meas_ff, meas_in;
   logic signed [ACC_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [MEAS_W-1:0] sm_ff, sm_in;
   logic                     started_ff, started_in;
   logic                     upd_ff, upd_in;
   logic                     clamp_ff, clamp_in;
   logic signed [MEAS_W-1:0] anchor_ff [NUM_LEGS];
   logic signed [MEAS_W-1:0] anchor_in [NUM_LEGS];
   logic [NUM_LEGS-1:0]      avalid_ff, avalid_in;
   logic [NUM_LEGS-1:0]      was_ff, was_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_data_type             rsp_data_ff, rsp_data_in;

   logic signed [ACC_W-1:0]  alu_a, alu_b;
   logic                     alu_sub;
   alu_res_type              alu_res;

   logic signed [MEAS_W-1:0] offs [IN_LEGS];
   logic [LEGX_W-1:0]        leg_wide;
   logic [1:0]               leg_lo;
   logic                     leg_stance, leg_ok, leg_need, leg_last;
   logic signed [MEAS_W-1:0] leg_off;
   logic [MINL_W-1:0]        minl_eff;
   logic [GAIN_W-1:0]        gain_eff;
   logic signed [GAIN_W:0]   mul_a;
   logic signed [MEAS_W-1:0] mul_b;
   logic signed [ACC_W-1:0]  mul_p;
   logic signed [ACC_W-1:0]  lim_ext;
   logic                     over_hi, over_lo;
   logic                     accept, slot_free;

   lahc_alu u_alu (
      .a_in (alu_a),
      .b_in (alu_b),
      .sub  (alu_sub),
      .res  (alu_res)
   );

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   assign offs[0] = in_ff.leg0_foot_offset;
   assign offs[1] = in_ff.leg1_foot_offset;
   assign offs[2] = in_ff.leg2_foot_offset;
   assign offs[3] = in_ff.leg3_foot_offset;

   assign leg_wide   = LEGX_W'(leg_ff);
   assign leg_lo     = leg_wide[1:0];
   assign leg_stance = (leg_wide < LEGX_W'(IN_LEGS)) && in_ff.stance_mask[leg_lo];
   assign leg_ok     = in_ff.offset_ok_mask[leg_lo];
   assign leg_off    = offs[leg_lo];
   assign leg_need   = !was_ff[leg_ff] || !avalid_ff[leg_ff];
   assign leg_last   = (leg_ff == LEG_W'(NUM_LEGS - 1));

   assign minl_eff = (minl_ff == '0) ? MINL_W'(1) :
                     (minl_ff > MINL_W'(4)) ? MINL_W'(4) : minl_ff;
   assign gain_eff = (gain_ff > ONE_Q16) ? ONE_Q16 : gain_ff;

   assign mul_a = (state_ff == S_MUL1) ? $signed({1'b0, gain_eff})
                                       : $signed({1'b0, ONE_Q16 - gain_eff});
   assign mul_b = (state_ff == S_MUL1) ? meas_ff : sm_ff;
   assign mul_p = ACC_W'(mul_a) * ACC_W'(mul_b);

   assign lim_ext = ACC_W'(lim_ff);
   assign over_hi = (lim_ff != '0) && (alu_res.sum > lim_ext);
   assign over_lo = (lim_ff != '0) && (alu_res.sum < -lim_ext);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_START;
         end
         S_START: begin
            if (!en_ff) begin
               state_in = S_EMIT;
            end else if (flat_ff) begin
               if (in_ff.reported_height_ok && (in_ff.stance_leg_count >= minl_eff))
                  state_in = S_FLAT;
               else
                  state_in = S_EMIT;
            end else begin
               state_in = S_LEG;
            end
         end
         S_LEG: begin
            if (leg_stance && leg_ok) state_in = S_SUM_A;
            else if (leg_last) state_in = S_AVG;
         end
         S_SUM_A: state_in = S_SUM_B;
         S_SUM_B: state_in = leg_last ? S_AVG : S_LEG;
         S_AVG: begin
            if (var_ff && (cnt_ff >= minl_eff)) state_in = S_DIV;
            else state_in = S_EMIT;
         end
         S_DIV: begin
            if (dcnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) state_in = S_DIV_FIX;
         end
         S_DIV_FIX: state_in = S_SMOOTH;
         S_FLAT: state_in = var_ff ? S_SMOOTH : S_EMIT;
         S_SMOOTH: state_in = started_ff ? S_MUL1 : S_CLAMP;
         S_MUL1: state_in = S_ACC1;
         S_ACC1: state_in = S_MUL2;
         S_MUL2: state_in = S_ACC2;
         S_ACC2: state_in = S_CLAMP;
         S_CLAMP: state_in = (over_hi || over_lo) ? S_BOUND : S_EMIT;
         S_BOUND: state_in = S_EMIT;
         S_EMIT: begin
            if (slot_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // shared adder operands
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      case (state_ff)
         S_LEG: begin
            alu_a = ACC_W'(in_ff.estimated_base_height);
            alu_b = ACC_W'(leg_off);
         end
         S_SUM_A: begin
            alu_a = ACC_W'(sum_ff);
            alu_b = ACC_W'(anchor_ff[leg_ff]);
         end
         S_SUM_B: begin
            alu_a   = ACC_W'(sum_ff);
            alu_b   = ACC_W'(leg_off);
            alu_sub = 1'b1;
         end
         S_AVG: begin
            alu_b   = ACC_W'(sum_ff);
            alu_sub = 1'b1;
         end
         S_DIV_FIX: begin
            alu_b   = ACC_W'(sum_ff);
            alu_sub = neg_ff;
         end
         S_FLAT: begin
            alu_a = ACC_W'(in_ff.reported_base_height);
            alu_b = ACC_W'(gnd_ff);
         end
         S_ACC1: begin
            alu_a = prod_ff;
            alu_b = ACC_W'(HALF_Q16);
         end
         S_ACC2: begin
            alu_a = acc_ff;
            alu_b = prod_ff;
         end
         S_CLAMP: begin
            alu_a   = ACC_W'(sm_ff);
            alu_b   = ACC_W'(in_ff.estimated_base_height);
            alu_sub = 1'b1;
         end
         S_BOUND: begin
            alu_a   = ACC_W'(in_ff.estimated_base_height);
            alu_b   = lim_ext;
            alu_sub = dir_ff;
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   // datapath
   always_comb begin
      logic [SUM_W-1:0] dq;
      logic [1:0]       dr;
      logic [2:0]       dt;

      en_in      = en_ff;
      flat_in    = flat_ff;
      gnd_in     = gnd_ff;
      var_in     = var_ff;
      lim_in     = lim_ff;
      gain_in    = gain_ff;
      minl_in    = minl_ff;
      in_in      = in_ff;
      leg_in     = leg_ff;
      cnt_in     = cnt_ff;
      sum_in     = sum_ff;
      rem_in     = rem_ff;
      dcnt_in    = dcnt_ff;
      neg_in     = neg_ff;
      dir_in     = dir_ff;
      meas_in    = meas_ff;
      prod_in    = prod_ff;
      acc_in     = acc_ff;
      sm_in      = sm_ff;
      started_in = started_ff;
      upd_in     = upd_ff;
      clamp_in   = clamp_ff;
      anchor_in  = anchor_ff;
      avalid_in  = avalid_ff;
      was_in     = was_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      dq = sum_ff;
      dr = rem_ff;
      dt = '0;

      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_CORRECTION_ENABLE: en_in   = csr_wdata[0];
            CSR_FLAT_GROUND_MODE:  flat_in = csr_wdata[0];
            CSR_GROUND_OFFSET:     gnd_in  = csr_wdata[MEAS_W-1:0];
            CSR_VARIANCE_POSITIVE: var_in  = csr_wdata[0];
            CSR_MAX_INNOVATION:    lim_in  = csr_wdata[LIM_W-1:0];
            CSR_SMOOTHING_GAIN:    gain_in = csr_wdata[GAIN_W-1:0];
            CSR_MIN_STANCE_LEGS:   minl_in = csr_wdata[MINL_W-1:0];
            default: en_in = en_ff;
         endcase
      end

      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) in_in = req_chan.data;
         end
         S_START: begin
            leg_in   = '0;
            cnt_in   = '0;
            sum_in   = '0;
            upd_in   = 1'b0;
            clamp_in = 1'b0;
         end
         S_LEG: begin
            if (!leg_stance) begin
               avalid_in[leg_ff] = 1'b0;
               was_in[leg_ff]    = 1'b0;
            end else if (leg_ok && leg_need) begin
               anchor_in[leg_ff] = alu_res.sat;
               avalid_in[leg_ff] = 1'b1;
            end
            if (!(leg_stance && leg_ok) && !leg_last) leg_in = leg_ff + LEG_W'(1);
         end
         S_SUM_A: sum_in = alu_res.sum[SUM_W-1:0];
         S_SUM_B: begin
            sum_in         = alu_res.sum[SUM_W-1:0];
            cnt_in         = cnt_ff + CNT_W'(1);
            was_in[leg_ff] = 1'b1;
            if (!leg_last) leg_in = leg_ff + LEG_W'(1);
         end
         S_AVG: begin
            neg_in  = sum_ff[SUM_W-1];
            sum_in  = sum_ff[SUM_W-1] ? alu_res.sum[SUM_W-1:0] : sum_ff;
            rem_in  = '0;
            dcnt_in = '0;
         end
         S_DIV: begin
            for (int k = 0; k < 2; k++) begin
               dt = {dr, dq[SUM_W-1]};
               dq = {dq[SUM_W-2:0], 1'b0};
               if (dt >= cnt_ff) begin
                  dr    = 2'(dt - cnt_ff);
                  dq[0] = 1'b1;
               end else begin
                  dr = dt[1:0];
               end
            end
            sum_in  = dq;
            rem_in  = dr;
            dcnt_in = dcnt_ff + DIV_CNT_W'(1);
         end
         S_DIV_FIX: meas_in = alu_res.sat;
         S_FLAT:    meas_in = alu_res.sat;
         S_SMOOTH: begin
            if (!started_ff) begin
               sm_in      = meas_ff;
               started_in = 1'b1;
            end
         end
         S_MUL1: prod_in = mul_p;
         S_ACC1: acc_in  = alu_res.sum;
         S_MUL2: prod_in = mul_p;
         S_ACC2: sm_in   = alu_res.sat_q16;
         S_CLAMP: begin
            upd_in = 1'b1;
            dir_in = over_lo;
         end
         S_BOUND: begin
            sm_in    = alu_res.sat;
            clamp_in = 1'b1;
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in                   = 1'b1;
               rsp_data_in.update_valid       = upd_ff;
               rsp_data_in.height_measurement = upd_ff ? sm_ff : '0;
               rsp_data_in.innovation_clamped = upd_ff && clamp_ff;
            end
         end
         default: begin
            leg_in = leg_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         en_ff        <= 1'b1;
         flat_ff      <= 1'b0;
         gnd_ff       <= '0;
         var_ff       <= 1'b1;
         lim_ff       <= LIM_W'(16384);
         gain_ff      <= ONE_Q16;
         minl_ff      <= MINL_W'(1);
         avalid_ff    <= '0;
         was_ff       <= '0;
         started_ff   <= 1'b0;
         sm_ff        <= '0;
         upd_ff       <= 1'b0;
         clamp_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         en_ff        <= en_in;
         flat_ff      <= flat_in;
         gnd_ff       <= gnd_in;
         var_ff       <= var_in;
         lim_ff       <= lim_in;
         gain_ff      <= gain_in;
         minl_ff      <= minl_in;
         avalid_ff    <= avalid_in;
         was_ff       <= was_in;
         started_ff   <= started_in;
         sm_ff        <= sm_in;
         upd_ff       <= upd_in;
         clamp_ff     <= clamp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff       <= in_in;
      leg_ff      <= leg_in;
      cnt_ff      <= cnt_in;
      sum_ff      <= sum_in;
      rem_ff      <= rem_in;
      dcnt_ff     <= dcnt_in;
      neg_ff      <= neg_in;
      dir_ff      <= dir_in;
      meas_ff     <= meas_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      anchor_ff   <= anchor_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== design/lahc_checker.sv =====
// ----------------------------------------------------------------------------
// lahc_checker
// Port-level checks of the height conditioner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lahc_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire lahc_pkg::rsp_data_type rsp_data
);
   import lahc_pkg::*;

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("outputs not idle after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second sample taken while one is in work");

   a_no_update_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.update_valid) |->
         (rsp_data.height_measurement == '0) && !rsp_data.innovation_clamped)
      else $error("result without update carries data");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind leg_anchor_height_conditioner_core lahc_checker u_lahc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);

`default_nettype wire

// ===== sim/tb_leg_anchor_height_conditioner_core.sv =====
// ----------------------------------------------------------------------------
// tb_leg_anchor_height_conditioner_core
// Self-checking bench for the leg anchor height conditioner. A queue-fed driver
// sends odometry samples over the request channel. A clocked monitor checks
// every measurement transfer against a local model that tracks foot anchors,
// averaging, smoothing and the innovation clamp. Directed corner cases run
// first, then gait-like random traffic under randomized register settings and
// varying back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_leg_anchor_height_conditioner_core;
   import lahc_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int RAND_PHASES = 12;
   localparam int PHASE_ITEMS = 128;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   lahc_req_if req_chan ();
   lahc_rsp_if rsp_chan ();

   leg_anchor_height_conditioner_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // register shadow
   logic                     cfg_enable;
   logic                     cfg_flat;
   logic signed [MEAS_W-1:0] cfg_ground_offset;
   logic                     cfg_var_pos;
   logic [LIM_W-1:0]         cfg_max_innov;
   logic [GAIN_W-1:0]        cfg_gain;
   logic [MINL_W-1:0]        cfg_min_legs;

   // height tracking state
   logic signed [MEAS_W-1:0] anchor_z [IN_LEGS];
   logic                     anchor_ok [IN_LEGS];
   logic                     stance_prev [IN_LEGS];
   logic signed [MEAS_W-1:0] smooth_z;
   logic                     smooth_primed;

   // gait generator state
   logic [IN_LEGS-1:0] gait_mask;
   int                 walk_base;

   req_data_type pending_q [$];
   rsp_data_type height_q [$];

   int idle_mode;
   int err_count;
   int sample_count;
   int issued_count;
   int clamped_count;
   int setting_count;
   int cycle_count;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic signed [MEAS_W-1:0] sat32(longint v);
      if (v > longint'(MEAS_MAX)) return MEAS_MAX;
      if (v < longint'(MEAS_MIN)) return MEAS_MIN;
      return v[MEAS_W-1:0];
   endfunction

   function automatic rsp_data_type predict_height(req_data_type s);
      logic signed [MEAS_W-1:0] off [IN_LEGS];
      logic signed [MEAS_W-1:0] base;
      logic signed [MEAS_W-1:0] meas;
      longint                   sum;
      longint                   count;
      longint                   g;
      longint                   acc;
      longint                   innov;
      longint                   lim;
      int                       minl;
      logic                     have_meas;
      rsp_data_type             r;
      r = '0;
      have_meas = 1'b0;
      meas = '0;
      base = s.estimated_base_height;
      off[0] = s.leg0_foot_offset;
      off[1] = s.leg1_foot_offset;
      off[2] = s.leg2_foot_offset;
      off[3] = s.leg3_foot_offset;
      minl = (cfg_min_legs == 0) ? 1 : (cfg_min_legs > 4) ? 4 : int'(cfg_min_legs);
      if (cfg_enable) begin
         if (cfg_flat) begin
            if (s.reported_height_ok && int'(s.stance_leg_count) >= minl) begin
               have_meas = 1'b1;
               meas = sat32(longint'(s.reported_base_height) + longint'(cfg_ground_offset));
            end
         end else begin
            sum = 0;
            count = 0;
            for (int leg = 0; leg < IN_LEGS; leg++) begin
               if (!s.stance_mask[leg]) begin
                  anchor_ok[leg] = 1'b0;
                  stance_prev[leg] = 1'b0;
               end else if (s.offset_ok_mask[leg]) begin
                  if (!stance_prev[leg] || !anchor_ok[leg]) begin
                     anchor_z[leg] = sat32(longint'(base) + longint'(off[leg]));
                     anchor_ok[leg] = 1'b1;
                  end
                  sum += longint'(anchor_z[leg]) - longint'(off[leg]);
                  count++;
                  stance_prev[leg] = 1'b1;
               end
            end
            if (count >= minl) begin
               have_meas = 1'b1;
               meas = sat32(sum / count);
            end
         end
      end
      if (have_meas && cfg_var_pos) begin
         if (!smooth_primed) begin
            smooth_z = meas;
            smooth_primed = 1'b1;
         end else begin
            g = (cfg_gain > ONE_Q16) ? longint'(ONE_Q16) : longint'(cfg_gain);
            acc = g * longint'(meas) + (longint'(ONE_Q16) - g) * longint'(smooth_z);
            smooth_z = sat32((acc + longint'(HALF_Q16)) >>> FRAC_W);
         end
         innov = longint'(smooth_z) - longint'(base);
         lim = longint'(cfg_max_innov);
         if (lim > 0 && innov > lim) begin
            smooth_z = sat32(longint'(base) + lim);
            r.innovation_clamped = 1'b1;
         end else if (lim > 0 && innov < -lim) begin
            smooth_z = sat32(longint'(base) - lim);
            r.innovation_clamped = 1'b1;
         end
         r.update_valid = 1'b1;
         r.height_measurement = smooth_z;
      end
      return r;
   endfunction

   function automatic req_data_type mk(logic [3:0] stance, logic [3:0] okm,
                                       logic signed [31:0] o0, logic signed [31:0] o1,
                                       logic signed [31:0] o2, logic signed [31:0] o3,
                                       logic signed [31:0] base, logic signed [31:0] rep,
                                       logic rep_ok, logic [2:0] cnt);
      req_data_type s;
      s.stance_mask = stance;
      s.offset_ok_mask = okm;
      s.leg0_foot_offset = o0;
      s.leg1_foot_offset = o1;
      s.leg2_foot_offset = o2;
      s.leg3_foot_offset = o3;
      s.estimated_base_height = base;
      s.reported_base_height = rep;
      s.reported_height_ok = rep_ok;
      s.stance_leg_count = cnt;
      return s;
   endfunction

   function automatic logic signed [31:0] pick_extreme();
      case ($urandom_range(3))
         0: return MEAS_MIN;
         1: return MEAS_MAX;
         2: return 32'sd0;
         default: return -32'sd1;
      endcase
   endfunction

   function automatic req_data_type next_sample();
      req_data_type s;
      logic signed [31:0] off [IN_LEGS];
      s = '0;
      if ($urandom_range(99) < 8) begin
         s = mk(4'($urandom), 4'($urandom), $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, 1'($urandom), 3'($urandom_range(4)));
      end else begin
         for (int leg = 0; leg < IN_LEGS; leg++) begin
            if ($urandom_range(7) == 0) gait_mask[leg] = ~gait_mask[leg];
            off[leg] = -32768 + int'($urandom_range(8000)) - 4000;
         end
         if ($urandom_range(19) == 0) off[$urandom_range(IN_LEGS-1)] = pick_extreme();
         walk_base = walk_base + int'($urandom_range(3000)) - 1500;
         if (walk_base > 300000 || walk_base < -300000) walk_base = 32768;
         s = mk(gait_mask, ($urandom_range(9) == 0) ? 4'($urandom) : 4'hF,
                off[0], off[1], off[2], off[3], walk_base,
                walk_base + int'($urandom_range(2000)) - 1000,
                $urandom_range(9) != 0,
                ($urandom_range(4) == 0) ? 3'($urandom_range(4)) : 3'($countones(gait_mask)));
         if ($urandom_range(19) == 0) s.estimated_base_height = pick_extreme();
         if ($urandom_range(19) == 0) s.reported_base_height = pick_extreme();
      end
      return s;
   endfunction

   function automatic bit sender_rests();
      case (idle_mode)
         0: return $urandom_range(99) < 23;
         1: return $urandom_range(99) < 69;
         default: return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_rests();
      case (idle_mode)
         0: return $urandom_range(99) < 69;
         1: return $urandom_range(99) < 23;
         default: return 1'b0;
      endcase
   endfunction

   task automatic set_reg(csr_index_type idx, logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_CORRECTION_ENABLE: cfg_enable = val[0];
         CSR_FLAT_GROUND_MODE:  cfg_flat = val[0];
         CSR_GROUND_OFFSET:     cfg_ground_offset = val;
         CSR_VARIANCE_POSITIVE: cfg_var_pos = val[0];
         CSR_MAX_INNOVATION:    cfg_max_innov = val[LIM_W-1:0];
         CSR_SMOOTHING_GAIN:    cfg_gain = val[GAIN_W-1:0];
         CSR_MIN_STANCE_LEGS:   cfg_min_legs = val[MINL_W-1:0];
         default: ;
      endcase
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_we <= 1'b0;
      setting_count++;
      @(negedge clock);
   endtask

   // hold off until every queued sample has produced its measurement
   task automatic drain();
      do @(negedge clock);
      while (pending_q.size() != 0 || height_q.size() != 0 || req_chan.valid);
   endtask

   task automatic randomize_settings();
      logic [31:0] v;
      set_reg(CSR_CORRECTION_ENABLE, $urandom_range(9) != 0);
      set_reg(CSR_FLAT_GROUND_MODE, $urandom_range(2) == 0);
      case ($urandom_range(3))
         0: v = MEAS_MIN;
         1: v = MEAS_MAX;
         2: v = $urandom_range(131072) - 65536;
         default: v = $urandom;
      endcase
      set_reg(CSR_GROUND_OFFSET, v);
      set_reg(CSR_VARIANCE_POSITIVE, $urandom_range(9) != 0);
      case ($urandom_range(4))
         0: v = 0;
         1: v = 1;
         2: v = 32'h7FFF_FFFF;
         3: v = $urandom_range(65536, 1);
         default: v = $urandom & 32'h7FFF_FFFF;
      endcase
      set_reg(CSR_MAX_INNOVATION, v);
      case ($urandom_range(3))
         0: v = 0;
         1: v = 65536;
         2: v = $urandom_range(65535, 1);
         default: v = $urandom_range(131071, 65537);
      endcase
      set_reg(CSR_SMOOTHING_GAIN, v);
      set_reg(CSR_MIN_STANCE_LEGS, $urandom_range(7));
      end_writes();
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            height_q.push_back(predict_height(pending_q.pop_front()));
            sample_count++;
         end
         if (req_chan.valid && !req_chan.ready) begin
            // hold the current transfer
         end else if (pending_q.size() != 0 && !sender_rests()) begin
            req_chan.valid <= 1'b1;
            req_chan.data <= pending_q[0];
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // measurement monitor
   always @(posedge clock) begin : monitor
      rsp_data_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (height_q.size() == 0) begin
               $display("%0t: unexpected measurement transfer: expected none, actual %p",
                        $time, rsp_chan.data);
               err_count++;
            end else begin
               want = height_q.pop_front();
               if (rsp_chan.data.update_valid !== want.update_valid) begin
                  $display("%0t: update_valid mismatch: expected %0b, actual %0b",
                           $time, want.update_valid, rsp_chan.data.update_valid);
                  err_count++;
               end
               if (rsp_chan.data.height_measurement !== want.height_measurement) begin
                  $display("%0t: height_measurement mismatch: expected %0d, actual %0d",
                           $time, want.height_measurement, rsp_chan.data.height_measurement);
                  err_count++;
               end
               if (rsp_chan.data.innovation_clamped !== want.innovation_clamped) begin
                  $display("%0t: innovation_clamped mismatch: expected %0b, actual %0b",
                           $time, want.innovation_clamped, rsp_chan.data.innovation_clamped);
                  err_count++;
               end
               if (want.update_valid) issued_count++;
               if (want.innovation_clamped) clamped_count++;
            end
         end
         rsp_chan.ready <= !receiver_rests();
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_leg_anchor_height_conditioner_core failed");
         $finish;
      end
   end

   initial begin : stimulus
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data = '0;
      rsp_chan.ready = 1'b0;
      csr_we = 1'b0;
      csr_addr = CSR_CORRECTION_ENABLE;
      csr_wdata = '0;
      idle_mode = 0;
      err_count = 0;
      sample_count = 0;
      issued_count = 0;
      clamped_count = 0;
      setting_count = 1;
      cycle_count = 0;
      cfg_enable = 1'b1;
      cfg_flat = 1'b0;
      cfg_ground_offset = '0;
      cfg_var_pos = 1'b1;
      cfg_max_innov = 16384;
      cfg_gain = ONE_Q16;
      cfg_min_legs = 1;
      for (int leg = 0; leg < IN_LEGS; leg++) begin
         anchor_z[leg] = '0;
         anchor_ok[leg] = 1'b0;
         stance_prev[leg] = 1'b0;
      end
      smooth_z = '0;
      smooth_primed = 1'b0;
      gait_mask = 4'hF;
      walk_base = 32768;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // anchor mode at reset settings: first sample, held anchors, saturation
      pending_q.push_back(mk(4'hF, 4'hF, -32768, -32768, -32768, -32768, 32768, 0, 0, 0));
      pending_q.push_back(mk(4'hF, 4'hF, -33000, -33000, -33000, -33000, 40000, 0, 0, 0));
      pending_q.push_back(mk(4'h0, 4'hF, -33000, -33000, -33000, -33000, 40000, 0, 0, 0));
      pending_q.push_back(mk(4'hF, 4'h0, -33000, -33000, -33000, -33000, 40000, 0, 0, 0));
      pending_q.push_back(mk(4'h5, 4'hF, MEAS_MAX, MEAS_MAX, MEAS_MAX, MEAS_MAX,
                             MEAS_MAX, 0, 0, 0));
      pending_q.push_back(mk(4'h5, 4'hF, MEAS_MIN, MEAS_MIN, MEAS_MIN, MEAS_MIN,
                             MEAS_MIN, 0, 0, 0));
      pending_q.push_back(mk(4'hA, 4'hA, MEAS_MIN, MEAS_MIN, MEAS_MIN, MEAS_MIN,
                             MEAS_MAX, 0, 0, 0));
      drain();

      // correction off: no state change
      set_reg(CSR_CORRECTION_ENABLE, 0);
      end_writes();
      pending_q.push_back(mk(4'hF, 4'hF, -32768, -32768, -32768, -32768, 20000, 0, 0, 0));
      drain();

      // variance flag low: anchors move, no update
      set_reg(CSR_CORRECTION_ENABLE, 1);
      set_reg(CSR_VARIANCE_POSITIVE, 0);
      end_writes();
      pending_q.push_back(mk(4'h3, 4'h3, -30000, -31000, 0, 0, 30000, 0, 0, 0));
      drain();

      // no clamp, oversize gain, zero leg minimum
      set_reg(CSR_VARIANCE_POSITIVE, 1);
      set_reg(CSR_MAX_INNOVATION, 0);
      set_reg(CSR_SMOOTHING_GAIN, 32'h1FFFF);
      set_reg(CSR_MIN_STANCE_LEGS, 0);
      end_writes();
      pending_q.push_back(mk(4'h1, 4'h1, -30000, 0, 0, 0, 30000, 0, 0, 0));
      drain();
      set_reg(CSR_SMOOTHING_GAIN, 0);
      end_writes();
      pending_q.push_back(mk(4'h3, 4'h3, -40000, -40000, 0, 0, 100000, 0, 0, 0));
      drain();
      set_reg(CSR_SMOOTHING_GAIN, 32768);
      end_writes();
      pending_q.push_back(mk(4'h3, 4'h3, -12345, -777, 0, 0, 5, 0, 0, 0));
      drain();

      // leg minimum above four acts as four
      set_reg(CSR_MIN_STANCE_LEGS, 7);
      end_writes();
      pending_q.push_back(mk(4'h7, 4'hF, -20000, -21000, -22000, -23000, 40000, 0, 0, 0));
      pending_q.push_back(mk(4'hF, 4'hF, -20000, -21000, -22000, -23000, 40000, 0, 0, 0));
      drain();

      // flat ground mode with saturating offsets
      set_reg(CSR_FLAT_GROUND_MODE, 1);
      set_reg(CSR_GROUND_OFFSET, MEAS_MAX);
      set_reg(CSR_MIN_STANCE_LEGS, 2);
      set_reg(CSR_MAX_INNOVATION, 32'h7FFF_FFFF);
      end_writes();
      pending_q.push_back(mk(4'hF, 4'hF, 0, 0, 0, 0, 0, MEAS_MAX, 1, 4));
      pending_q.push_back(mk(4'hF, 4'hF, 0, 0, 0, 0, 0, 1000, 0, 4));
      pending_q.push_back(mk(4'h1, 4'hF, 0, 0, 0, 0, 0, 1000, 1, 1));
      drain();
      set_reg(CSR_GROUND_OFFSET, MEAS_MIN);
      end_writes();
      pending_q.push_back(mk(4'h3, 4'hF, 0, 0, 0, 0, -5, MEAS_MIN, 1, 2));
      pending_q.push_back(mk(4'h0, 4'hF, 0, 0, 0, 0, -5, 7, 1, 0));
      drain();

      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         idle_mode = phase / 4;
         randomize_settings();
         repeat (PHASE_ITEMS) pending_q.push_back(next_sample());
         drain();
      end

      repeat (50) @(posedge clock);
      $display("run covered %0d samples over %0d register settings", sample_count,
               setting_count);
      $display("%0d measurements issued, %0d of them clamped", issued_count, clamped_count);
      if (err_count == 0) begin
         $display("tb_leg_anchor_height_conditioner_core passed");
      end else begin
         $display("tb_leg_anchor_height_conditioner_core failed");
      end
      $finish;
   end

endmodule
